[rtl/core/sdaf_pkg.sv]
// ----------------------------------------------------------------------------
// sdaf_pkg
// Shared constants and types for the signed decimal ASCII formatter.
// ----------------------------------------------------------------------------
package sdaf_pkg;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Converter to emitter hand-off status
    typedef struct packed {
        logic valid;
        logic negative;
    } t_conv_info;

endpackage

[rtl/core/sdaf_bin2bcd.sv]
// ----------------------------------------------------------------------------
// sdaf_bin2bcd
// Bit-serial binary to BCD converter (shift and add-3), one input bit per
// cycle. Holds the finished digits until the emitter takes them.
// ----------------------------------------------------------------------------
module sdaf_bin2bcd
    import sdaf_pkg::*;
#(
    parameter int VALUE_WIDTH = 32,
    parameter int NUM_DIGITS  = 12
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [VALUE_WIDTH-1:0]    i_value,
    output t_conv_info                o_info,
    output logic [4*NUM_DIGITS-1:0]   o_bcd,
    input  logic                      i_take
);

    localparam int CW = $clog2(VALUE_WIDTH + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]              r_state, n_state;
    logic [CW-1:0]           r_cnt, n_cnt;
    logic [VALUE_WIDTH-1:0]  r_bin, n_bin;
    logic [4*NUM_DIGITS-1:0] r_bcd, n_bcd;
    logic                    r_neg, n_neg;
    logic [4*NUM_DIGITS-1:0] w_adj;

    // Add 3 to every digit of five or more before the doubling shift
    always_comb begin
        logic [3:0] v_dig;
        v_dig = '0;
        for (int d = 0; d < NUM_DIGITS; d++) begin
            v_dig = r_bcd[d*4 +: 4];
            w_adj[d*4 +: 4] = (v_dig >= 4'd5) ? v_dig + 4'd3 : v_dig;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        n_neg   = r_neg;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_neg   = i_value[VALUE_WIDTH-1];
                    n_bin   = i_value[VALUE_WIDTH-1] ? -i_value : i_value;
                    n_bcd   = '0;
                    n_cnt   = CW'(VALUE_WIDTH);
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                n_bcd = {w_adj[4*NUM_DIGITS-2:0], r_bin[VALUE_WIDTH-1]};
                n_bin = {r_bin[VALUE_WIDTH-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_bin <= n_bin;
        r_bcd <= n_bcd;
        r_neg <= n_neg;
    end

    assign o_stall         = (r_state != ST_IDLE);
    assign o_info.valid    = (r_state == ST_DONE);
    assign o_info.negative = r_neg;
    assign o_bcd           = r_bcd;

endmodule

[rtl/core/sdaf_emit.sv]
// ----------------------------------------------------------------------------
// sdaf_emit
// Character emitter: sends the sign of a negative value, then scans the BCD
// digits from the top one per cycle unless stalled, dropping leading zeros.
// ----------------------------------------------------------------------------
module sdaf_emit
    import sdaf_pkg::*;
#(
    parameter int NUM_DIGITS  = 12,
    parameter int DIGIT_SLOTS = 12
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_conv_info                i_info,
    input  logic [4*NUM_DIGITS-1:0]   i_bcd,
    output logic                      o_take,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [7:0]                o_ascii_char,
    output logic                      o_last_char
);

    localparam int IW = $clog2(NUM_DIGITS);
    localparam logic [IW:0] SLOTS_W = (IW+1)'(DIGIT_SLOTS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SIGN = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;

    logic [1:0]              r_state, n_state;
    logic [4*NUM_DIGITS-1:0] r_dig, n_dig;
    logic [IW-1:0]           r_idx, n_idx;
    logic                    r_seen, n_seen;
    logic                    r_valid, n_valid;
    logic [7:0]              r_char, n_char;
    logic                    r_last, n_last;
    logic                    w_free;
    logic [3:0]              w_top;
    logic                    w_seen;

    assign w_free = !r_valid || !i_stall;
    assign w_top  = r_dig[4*NUM_DIGITS-1 -: 4];
    assign w_seen = r_seen || (w_top != 4'd0);
    assign o_take = (r_state == ST_IDLE) && i_info.valid;

    always_comb begin
        n_state = r_state;
        n_dig   = r_dig;
        n_idx   = r_idx;
        n_seen  = r_seen;
        n_valid = r_valid && i_stall;
        n_char  = r_char;
        n_last  = r_last;
        unique case (r_state)
            ST_IDLE: begin
                if (i_info.valid) begin
                    n_dig   = i_bcd;
                    n_idx   = IW'(NUM_DIGITS - 1);
                    n_seen  = 1'b0;
                    n_state = i_info.negative ? ST_SIGN : ST_SCAN;
                end
            end
            ST_SIGN: begin
                if (w_free) begin
                    n_valid = 1'b1;
                    n_char  = CHAR_MINUS;
                    n_last  = 1'b0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_free) begin
                    // Emit inside the slot window once a nonzero digit was seen;
                    // the units digit always goes out
                    if (({1'b0, r_idx} < SLOTS_W) && (w_seen || r_idx == '0)) begin
                        n_valid = 1'b1;
                        n_char  = CHAR_ZERO + {4'd0, w_top};
                        n_last  = (r_idx == '0);
                    end
                    n_seen = w_seen;
                    n_dig  = {r_dig[4*NUM_DIGITS-5:0], 4'd0};
                    n_idx  = r_idx - 1'b1;
                    if (r_idx == '0) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_dig  <= n_dig;
        r_idx  <= n_idx;
        r_seen <= n_seen;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_valid      = r_valid;
    assign o_ascii_char = r_char;
    assign o_last_char  = r_last;

endmodule

[rtl/core/signed_decimal_ascii_formatter_core.sv]
// The converter takes the next value while the emitter still scans the previous
// one; output stalls hold the emitter.
// Reset: synchronous, active low; clears both controllers and the output valid.
// ----------------------------------------------------------------------------
// signed_decimal_ascii_formatter_core
// Formats a signed value as decimal ASCII text, one character per word,
// most significant digit first, last character flagged.
// ----------------------------------------------------------------------------
module signed_decimal_ascii_formatter_core
    import sdaf_pkg::*;
#(
    parameter int VALUE_WIDTH = 32,
    parameter int DIGIT_SLOTS = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [VALUE_WIDTH-1:0] i_value,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [7:0]             o_ascii_char,
    output logic                   o_last_char
);

    localparam int FULL_DIGITS = (VALUE_WIDTH * 77) / 256 + 1;
    localparam int NUM_DIGITS  = (FULL_DIGITS > DIGIT_SLOTS) ? FULL_DIGITS : DIGIT_SLOTS;

    t_conv_info              w_info;
    logic [4*NUM_DIGITS-1:0] w_bcd;
    logic                    w_take;

    sdaf_bin2bcd #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .NUM_DIGITS  (NUM_DIGITS)
    ) u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_value (i_value),
        .o_info  (w_info),
        .o_bcd   (w_bcd),
        .i_take  (w_take)
    );

    sdaf_emit #(
        .NUM_DIGITS  (NUM_DIGITS),
        .DIGIT_SLOTS (DIGIT_SLOTS)
    ) u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_info       (w_info),
        .i_bcd        (w_bcd),
        .o_take       (w_take),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_ascii_char (o_ascii_char),
        .o_last_char  (o_last_char)
    );

endmodule

[rtl/core/sdaf_checker.sv]
// ----------------------------------------------------------------------------
// sdaf_checker
// Port-level checks on the formatter's output words and input flow.
// ----------------------------------------------------------------------------
module sdaf_checker
    import sdaf_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_ascii_char,
    input logic       o_last_char
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_ascii_char) && $stable(o_last_char))
        else $error("output word changed while stalled");

    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_ascii_char == CHAR_MINUS) ||
                    ((o_ascii_char >= CHAR_ZERO) && (o_ascii_char <= CHAR_NINE)))
        else $error("character is neither minus nor digit");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_ascii_char == CHAR_MINUS) |-> !o_last_char)
        else $error("minus sign flagged as last character");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("converter not busy after taking a value");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

bind signed_decimal_ascii_formatter_core sdaf_checker u_sdaf_checker (.*);

[test/tb_signed_decimal_ascii_formatter_core.sv]
// ----------------------------------------------------------------------------
// tb_signed_decimal_ascii_formatter_core
// Sends signed 32-bit values into the formatter and checks every ASCII word
// that comes back against decimal text worked out in the bench. Both sides
// idle and stall at random. A directed set covers zero, the extremes and the
// digit-count boundaries; a random set covers the rest of the value range.
// ----------------------------------------------------------------------------
module tb_signed_decimal_ascii_formatter_core;
    import sdaf_pkg::*;

    localparam int          WIDTH      = 32;
    localparam int          LIMIT      = 1_000_000;
    localparam int          RAND_ITEMS = 208;
    localparam int          DRAIN      = 60;
    localparam logic [31:0] RADIX      = 32'd10;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } t_char_word;

    class decimal_text_board;
        t_char_word pending_chars[$];
        int errors    = 0;
        int values    = 0;
        int negatives = 0;
        int longest   = 0;
        int words     = 0;

        // Expand one value into its expected characters, most significant first.
        function void add_number(logic [WIDTH-1:0] raw);
            logic [WIDTH-1:0] mag;
            logic [7:0]       digs[$];
            t_char_word       w;
            int               len;
            values++;
            if (raw == '0) begin
                w.ch   = CHAR_ZERO;
                w.last = 1'b1;
                pending_chars.push_back(w);
                if (longest < 1) longest = 1;
                return;
            end
            // most negative value wraps to its own unsigned magnitude
            mag = raw[WIDTH-1] ? ('0 - raw) : raw;
            while (mag != '0) begin
                digs.push_front(CHAR_ZERO + 8'(mag % RADIX));
                mag = mag / RADIX;
            end
            len = digs.size();
            if (raw[WIDTH-1]) begin
                negatives++;
                len++;
                w.ch   = CHAR_MINUS;
                w.last = 1'b0;
                pending_chars.push_back(w);
            end
            foreach (digs[k]) begin
                w.ch   = digs[k];
                w.last = (k == digs.size() - 1);
                pending_chars.push_back(w);
            end
            if (len > longest) longest = len;
        endfunction

        function void match_char(logic [7:0] ch, logic last);
            t_char_word w;
            words++;
            if (pending_chars.size() == 0) begin
                errors++;
                $display("%0t: unexpected word char=0x%02h last=%0b", $time, ch, last);
                return;
            end
            w = pending_chars.pop_front();
            if (ch !== w.ch) begin
                errors++;
                $display("%0t: char mismatch expected=0x%02h actual=0x%02h",
                         $time, w.ch, ch);
            end
            if (last !== w.last) begin
                errors++;
                $display("%0t: last mismatch expected=%0b actual=%0b",
                         $time, w.last, last);
            end
        endfunction

        function int outstanding();
            return pending_chars.size();
        endfunction
    endclass

    logic             i_clk   = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic [WIDTH-1:0] i_value = '0;
    logic             i_stall = 1'b0;
    logic             o_stall;
    logic             o_valid;
    logic [7:0]       o_ascii_char;
    logic             o_last_char;

    decimal_text_board board = new();

    int cycles     = 0;
    int stall_left = 0;
    int rx_quiet   = 0;
    int tx_quiet   = 0;

    logic signed [WIDTH-1:0] directed_vals[22] = '{
        0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 7, -42,
        2147483647, 32'sh80000000, -2147483647, 1000000000, 999999999,
        -999999999, 1234567890, -1234567890, 32'sh55555555, 32'shAAAAAAAA
    };

    signed_decimal_ascii_formatter_core #(
        .VALUE_WIDTH(WIDTH),
        .DIGIT_SLOTS(12)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_ascii_char(o_ascii_char),
        .o_last_char (o_last_char)
    );

    always #5 i_clk = ~i_clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [WIDTH-1:0] pow10(int k);
        logic [WIDTH-1:0] p;
        p = 1;
        repeat (k) p = p * RADIX;
        return p;
    endfunction

    function automatic logic [WIDTH-1:0] rand_value();
        logic [WIDTH-1:0] m;
        int               r;
        r = $urandom_range(0, 9);
        unique case (r)
            0, 1, 2, 3: m = $urandom;
            4, 5:       m = $urandom_range(0, 999);
            6:          m = $urandom_range(0, 99999);
            7:          m = pow10($urandom_range(0, 9)) - $urandom_range(0, 1);
            8:          m = 32'h7FFF_FFFF - $urandom_range(0, 20);
            default:    m = pow10($urandom_range(0, 9)) + $urandom_range(0, 3);
        endcase
        if (r != 8 && $urandom_range(0, 1)) m = '0 - m;
        if (r == 8 && $urandom_range(0, 1)) m = ~m;
        return m;
    endfunction

    task automatic send_value(input logic [WIDTH-1:0] v);
        int gap;
        if (tx_quiet > 0) begin
            tx_quiet--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 11) == 0) tx_quiet = $urandom_range(10, 30);
            gap = pick_gap();
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= v;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.add_number(v);
    endtask

    // drop valid and hold until every expected word is back
    task automatic drain_all();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.outstanding() != 0) @(posedge i_clk);
    endtask

    // receiver: check accepted words, then pick the next stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) board.match_char(o_ascii_char, o_last_char);
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (rx_quiet > 0) begin
                rx_quiet--;
                i_stall <= 1'b0;
            end else begin
                if ($urandom_range(0, 9) == 0) rx_quiet = $urandom_range(20, 80);
                else stall_left = pick_gap();
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycles, board.outstanding());
            $display("tb_signed_decimal_ascii_formatter_core: FAIL");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_vals[k]) send_value(directed_vals[k]);
        drain_all();

        for (int n = 0; n < RAND_ITEMS; n++) begin
            send_value(rand_value());
            if (n == RAND_ITEMS / 2) drain_all();
        end
        drain_all();
        repeat (DRAIN) @(posedge i_clk);

        $display("formatted %0d values (%0d negative) into %0d words, longest text %0d chars",
                 board.values, board.negatives, board.words, board.longest);
        $display("errors: %0d, cycles: %0d", board.errors, cycles);
        if (board.errors == 0 && board.outstanding() == 0) begin
            $display("tb_signed_decimal_ascii_formatter_core: PASS");
        end else begin
            $display("tb_signed_decimal_ascii_formatter_core: FAIL");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/sdaf_pkg.sv
rtl/core/sdaf_bin2bcd.sv
rtl/core/sdaf_emit.sv
rtl/core/signed_decimal_ascii_formatter_core.sv
rtl/core/sdaf_checker.sv
test/tb_signed_decimal_ascii_formatter_core.sv
